[sv/aip_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aip_pkg
// Types, parse phase codes, character codes and digit helpers for the
// ASCII integer parser.
// ----------------------------------------------------------------------------
package aip_pkg;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned RADIX_W = 6;
   localparam int unsigned DIGIT_W = 7;

   typedef logic [2:0]         phase_type;
   typedef logic [7:0]         char_type;
   typedef logic [RADIX_W-1:0] radix_type;
   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [VALUE_W-1:0] value_type;

   // Parse phases.
   localparam phase_type PH_SPACE  = 3'd0;
   localparam phase_type PH_PLUS   = 3'd1;
   localparam phase_type PH_PREFIX = 3'd2;
   localparam phase_type PH_ZERO   = 3'd3;
   localparam phase_type PH_DIGITS = 3'd4;
   localparam phase_type PH_DONE   = 3'd5;

   localparam digit_type NOT_DIGIT = 7'd127;

   localparam radix_type RADIX_AUTO = 6'd0;
   localparam radix_type RADIX_BIN  = 6'd2;
   localparam radix_type RADIX_OCT  = 6'd8;
   localparam radix_type RADIX_DEC  = 6'd10;
   localparam radix_type RADIX_HEX  = 6'd16;

   localparam char_type CH_SPACE = 8'h20;
   localparam char_type CH_TAB   = 8'h09;
   localparam char_type CH_CR    = 8'h0D;
   localparam char_type CH_MINUS = 8'h2D;
   localparam char_type CH_PLUS  = 8'h2B;
   localparam char_type CH_ZERO  = 8'h30;
   localparam char_type CH_NINE  = 8'h39;
   localparam char_type CH_UP_A  = 8'h41;
   localparam char_type CH_UP_Z  = 8'h5A;
   localparam char_type CH_LO_A  = 8'h61;
   localparam char_type CH_LO_Z  = 8'h7A;
   localparam char_type CH_UP_X  = 8'h58;
   localparam char_type CH_LO_X  = 8'h78;
   localparam char_type CH_UP_B  = 8'h42;
   localparam char_type CH_LO_B  = 8'h62;

   // Digit value 0..35 of a character, or NOT_DIGIT.
   function automatic digit_type digit_of(input char_type c);
      char_type d;
      d = '0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         d = c - CH_ZERO;
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
         d = c - CH_UP_A + 8'd10;
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
         d = c - CH_LO_A + 8'd10;
      end else begin
         d = {1'b0, NOT_DIGIT};
      end
      return d[DIGIT_W-1:0];
   endfunction

   function automatic logic is_space(input char_type c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   // Accumulator times a 6-bit radix, modulo 2^64, as a sum of shifted copies.
   function automatic value_type mul_radix(input value_type acc, input radix_type r);
      value_type sum;
      sum = '0;
      for (int i = 0; i < RADIX_W; i++) begin
         if (r[i]) begin
            sum = sum + (acc << i);
         end
      end
      return sum;
   endfunction

endpackage

[sv/ascii_integer_parser.sv]
`timescale 1ns / 1ps
// A result beat is offered once the last character has passed the input register
// and then the result register. Throughput: one character per cycle unless a
// last character waits on a full result register; the parse step is one
// multiply-add by the radix, between the input and parse state registers.
// Reset clears the parse state, the radix register (to auto-detect) and both
// the input and result valid flags.
// ----------------------------------------------------------------------------
// ascii_integer_parser
// Parses a length-delimited ASCII string, one byte per beat, into a signed
// 64-bit integer with optional whitespace, sign and radix prefix.
// ----------------------------------------------------------------------------
module ascii_integer_parser
   import aip_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_character,
   input  logic               req_last_char,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [63:0] rsp_value,
   input  logic               csr_wr_en,
   input  logic [5:0]         csr_wr_data
);

   radix_type csr_radix_ff;

   logic      in_valid_ff, in_valid_in;
   char_type  in_char_ff;
   logic      in_last_ff;

   phase_type phase_ff, phase_in;
   value_type acc_ff, acc_in;
   logic      neg_ff, neg_in;
   radix_type radix_ff, radix_in;

   logic      rsp_valid_ff, rsp_valid_in;
   value_type rsp_value_ff;

   logic      advance;
   logic      do_digit;
   radix_type dig_radix;
   digit_type digit;
   logic      autodetect;

   // The input register moves on unless it holds a last character that the
   // full result register cannot take.
   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   assign digit      = digit_of(in_char_ff);
   assign autodetect = (radix_ff == RADIX_AUTO);

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      radix_in  = radix_ff;
      do_digit  = 1'b0;
      dig_radix = radix_ff;

      unique case (phase_ff) inside
         PH_SPACE, PH_PLUS, PH_PREFIX: begin
            if (phase_ff == PH_SPACE && is_space(in_char_ff)) begin
               phase_in = PH_SPACE;
            end else if (phase_ff == PH_SPACE && in_char_ff == CH_MINUS) begin
               neg_in   = 1'b1;
               phase_in = PH_PLUS;
            end else if (phase_ff != PH_PREFIX && in_char_ff == CH_PLUS) begin
               phase_in = PH_PREFIX;
            end else if (phase_ff == PH_PLUS && in_char_ff == CH_MINUS) begin
               phase_in = PH_DONE;
            end else begin
               // First character after any whitespace and sign samples the radix register.
               radix_in = csr_radix_ff;
               if ((csr_radix_ff == RADIX_AUTO || csr_radix_ff == RADIX_HEX) &&
                   in_char_ff == CH_ZERO) begin
                  phase_in = PH_ZERO;
               end else begin
                  dig_radix = (csr_radix_ff == RADIX_AUTO) ? RADIX_DEC : csr_radix_ff;
                  radix_in  = dig_radix;
                  do_digit  = 1'b1;
               end
            end
         end
         PH_ZERO: begin
            if (in_char_ff == CH_LO_X || in_char_ff == CH_UP_X) begin
               radix_in = RADIX_HEX;
               phase_in = PH_DIGITS;
            end else if (autodetect && (in_char_ff == CH_LO_B || in_char_ff == CH_UP_B)) begin
               radix_in = RADIX_BIN;
               phase_in = PH_DIGITS;
            end else begin
               dig_radix = autodetect ? RADIX_OCT : radix_ff;
               radix_in  = dig_radix;
               do_digit  = 1'b1;
            end
         end
         PH_DIGITS: begin
            do_digit = 1'b1;
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      if (do_digit) begin
         if (digit < {1'b0, dig_radix}) begin
            acc_in   = mul_radix(acc_ff, dig_radix) + {{(VALUE_W-DIGIT_W){1'b0}}, digit};
            phase_in = PH_DIGITS;
         end else begin
            phase_in = PH_DONE;
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_radix_ff <= RADIX_AUTO;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_SPACE;
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         radix_ff     <= RADIX_AUTO;
      end else begin
         if (csr_wr_en) begin
            csr_radix_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            if (in_last_ff) begin
               // End of string: the parse state returns to its reset values.
               phase_ff <= PH_SPACE;
               acc_ff   <= '0;
               neg_ff   <= 1'b0;
               radix_ff <= RADIX_AUTO;
            end else begin
               phase_ff <= phase_in;
               acc_ff   <= acc_in;
               neg_ff   <= neg_in;
               radix_ff <= radix_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_char_ff <= req_character;
         in_last_ff <= req_last_char;
      end
      if (advance && in_last_ff) begin
         rsp_value_ff <= neg_in ? (~acc_in + 64'd1) : acc_in;
      end
   end

   // A stalled input register can only be a last character behind a full result.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && in_last_ff && rsp_valid_ff))
      else $error("input stalled without a pending result");

   // Once a string ends, the parse state is back at its start.
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (phase_ff == PH_SPACE && acc_ff == '0 && !neg_ff))
      else $error("parse state not cleared after last character");

   // A character that is not the last never raises a result.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && !(advance && in_last_ff)) |=> !rsp_valid_ff)
      else $error("result raised without a last character");

   // Digits are always accumulated under a nonzero radix.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DIGITS) |-> (radix_ff != RADIX_AUTO))
      else $error("digit phase with no radix chosen");

   // A pending result holds until taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_value_ff)))
      else $error("pending result changed before it was taken");

endmodule
